// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LPBL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define LPBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPBL_ASSERT(label, clk, rst, prop, msg)
`define LPBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/lpbl_pkg.sv
package lpbl_pkg;

  localparam int IDX_W  = 24;
  localparam int TAG_W  = 16;
  localparam int OFS_W  = 8;
  localparam int SLOT_W = 3;

  // one position of the recency list, frame number kept beside it
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } lpbl_entry_t;

  // per-cell lookup status
  typedef struct packed {
    logic hit;
    logic sel;
  } lpbl_cell_stat_t;

endpackage

// File: hw/rtl/lpbl_if.sv
interface lpbl_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpbl_pkg::IDX_W-1:0]  element_index;

  modport source (output valid, output element_index, input ready);
  modport sink   (input valid, input element_index, output ready);
endinterface

interface lpbl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lpbl_pkg::SLOT_W-1:0] frame_slot;
  logic [lpbl_pkg::OFS_W-1:0]  word_offset;
  logic                        was_hit;
  logic                        fetch_needed;
  logic [lpbl_pkg::TAG_W-1:0]  fetch_page;
  logic                        writeback_needed;
  logic [lpbl_pkg::TAG_W-1:0]  writeback_page;

  modport source (
    output valid, output frame_slot, output word_offset, output was_hit,
    output fetch_needed, output fetch_page, output writeback_needed,
    output writeback_page, input ready
  );
  modport sink (
    input valid, input frame_slot, input word_offset, input was_hit,
    input fetch_needed, input fetch_page, input writeback_needed,
    input writeback_page, output ready
  );
endinterface

// File: hw/rtl/lpbl_cell.sv
module lpbl_cell #(
  parameter int               FRAME_W     = 3,
  parameter logic [FRAME_W-1:0] RESET_FRAME = '0,
  parameter bit               IS_HEAD     = 1'b0,
  parameter bit               IS_LAST     = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic [lpbl_pkg::TAG_W-1:0]    key_tag,
  input  lpbl_pkg::lpbl_entry_t         prev_entry,
  input  logic [FRAME_W-1:0]            prev_frame,
  input  logic [FRAME_W-1:0]            head_frame,
  input  logic                          taken_in,
  output lpbl_pkg::lpbl_entry_t         entry,
  output logic [FRAME_W-1:0]            frame,
  output logic                          taken_out,
  output lpbl_pkg::lpbl_cell_stat_t     stat
);
  import lpbl_pkg::*;

  logic match;
  logic claim;

  // a free entry or a matching one stops the search here
  assign match     = entry.valid && (entry.tag == key_tag);
  assign claim     = !entry.valid || match;
  assign taken_out = taken_in | claim;
  assign stat.hit  = match;
  // the last position is selected when no earlier one claimed, for eviction if it claims nothing itself
  assign stat.sel  = IS_LAST ? !taken_in : (claim && !taken_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      entry.tag   <= '0;
      frame       <= RESET_FRAME;
    end else if (update) begin
      if (IS_HEAD) begin
        entry.valid <= 1'b1;
        entry.tag   <= key_tag;
        frame       <= head_frame;
      end else if (!taken_in) begin
        entry <= prev_entry;
        frame <= prev_frame;
      end
    end
  end

endmodule

// File: hw/rtl/lru_page_buffer_lookup_top.sv
// an accepted item passes the s0, s1 and output registers to its result item on rsp
// throughput: one item per cycle while rsp.ready is high; the list is updated in the cell row
// and the page/offset split is a two-stage reciprocal multiply with correction
// reset: rst (synchronous) empties the pipeline and marks every list entry
// invalid with frame number equal to position, no clearing pass needed
`include "assert_macros.svh"

module lru_page_buffer_lookup_top #(
  parameter int PAGE_WORDS   = 256,
  parameter int BUFFER_PAGES = 8
) (
  input  logic       clk,
  input  logic       rst,
  lpbl_req_if.sink   req,
  lpbl_rsp_if.source rsp
);
  import lpbl_pkg::*;

  localparam int FRAME_W   = $clog2(BUFFER_PAGES);
  localparam int PAGE_BITS = $clog2(PAGE_WORDS);
  // reciprocal scale: quotient estimate is exact or one low
  localparam int SHIFT     = IDX_W + PAGE_BITS;
  localparam int RECIP_W   = IDX_W + 2;
  localparam int PROD_W    = SHIFT + IDX_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((64'd1 << SHIFT) / PAGE_WORDS);
  localparam logic [IDX_W-1:0]   DIVISOR = IDX_W'(PAGE_WORDS);

  // pipeline handshake: each stage moves when the one after it has room
  logic s0_valid, s1_valid, out_valid;
  logic s0_ready, s1_ready, out_ready;
  logic load_s0, load_s1, load_out;

  assign out_ready = !out_valid || rsp.ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign s0_ready  = !s0_valid || s1_ready;
  assign load_s0   = req.valid && s0_ready;
  assign load_s1   = s0_valid && s1_ready;
  assign load_out  = s1_valid && out_ready;
  assign req.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_ready)  s0_valid  <= req.valid;
      if (s1_ready)  s1_valid  <= s0_valid;
      if (out_ready) out_valid <= s1_valid;
    end
  end

  // stage 0: quotient estimate by reciprocal multiply
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx0;
  logic [IDX_W-1:0]  q0;

  assign prod = PROD_W'(req.element_index) * PROD_W'(RECIP_C);

  always_ff @(posedge clk) begin
    if (load_s0) begin
      idx0 <= req.element_index;
      q0   <= prod[SHIFT +: IDX_W];
    end
  end

  // stage 1: remainder and one-step correction
  logic [IDX_W-1:0] rem;
  logic             corr;
  logic [IDX_W-1:0] q_fix;
  logic [IDX_W-1:0] r_fix;
  logic [TAG_W-1:0] page1;
  logic [OFS_W-1:0] offset1;

  always_comb begin
    rem   = idx0 - IDX_W'(q0 * DIVISOR);
    corr  = (rem >= DIVISOR);
    q_fix = corr ? (q0 + IDX_W'(1)) : q0;
    r_fix = corr ? (rem - DIVISOR) : rem;
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      page1   <= q_fix[TAG_W-1:0];
      offset1 <= r_fix[OFS_W-1:0];
    end
  end

  // stage 2: row of list cells, position 0 is the most recent
  lpbl_entry_t     entries [BUFFER_PAGES];
  logic [FRAME_W-1:0] frames [BUFFER_PAGES];
  lpbl_cell_stat_t stats   [BUFFER_PAGES];
  logic            taken   [BUFFER_PAGES+1];
  logic [FRAME_W-1:0] head_frame;

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < BUFFER_PAGES; g++) begin : g_cell
    lpbl_entry_t        prev_entry;
    logic [FRAME_W-1:0] prev_frame;

    if (g == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_frame = '0;
    end else begin : g_body
      assign prev_entry = entries[g-1];
      assign prev_frame = frames[g-1];
    end

    lpbl_cell #(
      .FRAME_W     (FRAME_W),
      .RESET_FRAME (FRAME_W'(g)),
      .IS_HEAD     (g == 0),
      .IS_LAST     (g == BUFFER_PAGES - 1)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .update     (load_out),
      .key_tag    (page1),
      .prev_entry (prev_entry),
      .prev_frame (prev_frame),
      .head_frame (head_frame),
      .taken_in   (taken[g]),
      .entry      (entries[g]),
      .frame      (frames[g]),
      .taken_out  (taken[g+1]),
      .stat       (stats[g])
    );
  end

  // gather the selected frame and the hit flag from the row
  logic                    hit_any;
  logic                    full;
  logic [BUFFER_PAGES-1:0] sel_vec;
  logic [BUFFER_PAGES-1:0] valid_vec;
  logic [BUFFER_PAGES-1:0] frame_mask;
  logic [31:0]             head_frame_w;

  always_comb begin
    head_frame = '0;
    hit_any    = 1'b0;
    sel_vec    = '0;
    valid_vec  = '0;
    frame_mask = '0;
    for (int i = 0; i < BUFFER_PAGES; i++) begin
      if (stats[i].sel) head_frame = head_frame | frames[i];
      hit_any    = hit_any | stats[i].hit;
      sel_vec[i]   = stats[i].sel;
      valid_vec[i] = entries[i].valid;
      frame_mask[frames[i]] = 1'b1;
    end
  end

  // nobody claimed: list is full and the least recent entry is evicted
  assign full         = !taken[BUFFER_PAGES];
  assign head_frame_w = 32'(head_frame);

  // output register
  logic [SLOT_W-1:0] out_slot;
  logic [OFS_W-1:0]  out_offset;
  logic              out_hit;
  logic              out_fetch;
  logic [TAG_W-1:0]  out_fpage;
  logic              out_wb;
  logic [TAG_W-1:0]  out_wpage;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot   <= head_frame_w[SLOT_W-1:0];
      out_offset <= offset1;
      out_hit    <= hit_any;
      out_fetch  <= !hit_any;
      out_fpage  <= hit_any ? '0 : page1;
      out_wb     <= full;
      out_wpage  <= full ? entries[BUFFER_PAGES-1].tag : '0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.frame_slot       = out_slot;
  assign rsp.word_offset      = out_offset;
  assign rsp.was_hit          = out_hit;
  assign rsp.fetch_needed     = out_fetch;
  assign rsp.fetch_page       = out_fpage;
  assign rsp.writeback_needed = out_wb;
  assign rsp.writeback_page   = out_wpage;

  // exactly one position is picked in every cycle
  `LPBL_ASSERT(a_sel_onehot, clk, rst, $onehot(sel_vec), "lookup picked no or several positions")
  // valid entries stay packed at the front of the list
  `LPBL_ASSERT(a_valid_packed, clk, rst, (valid_vec & (valid_vec + 1'b1)) == '0, "valid gap")
  // frame numbers stay a permutation of all frames
  `LPBL_ASSERT(a_frames_perm, clk, rst, frame_mask == {BUFFER_PAGES{1'b1}}, "frame numbers lost or duplicated")
  // a lookup leaves a valid front entry and a pending result
  `LPBL_ASSERT_NEXT(a_head_valid, clk, rst, load_out, entries[0].valid && out_valid, "front entry not valid after lookup")

endmodule
